/* rtl/core/pip_pkg.sv */
package pip_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_VERTICES_DEF = 64;
  localparam int unsigned COORD_WIDTH_DEF  = 16;

  // Fixed field widths
  localparam int unsigned ACTION_W    = 2;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned RADIUS_W    = 10;
  localparam int unsigned COUNT_OUT_W = 7;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(15);

  // Sequencer to edge unit
  typedef struct packed {
    logic clear;
    logic feed;
  } edge_ctl_t;

  // Edge unit to sequencer
  typedef struct packed {
    logic busy;
    logic parity;
  } edge_sts_t;

endpackage

/* rtl/core/polygon_store_point_in_polygon.sv */
// Polygon store with point-in-polygon test.
//
// Input channel (in_valid_i / in_stall_o): one beat carries an action with an x/y pair.
// Add appends a vertex, or closes the shape when the point lies within close_radius of
// the first vertex, and is ignored on a closed shape or a full store; query tests the
// point by even-odd ray crossing against the closed shape and returns its bounding box;
// clear empties the store. Output channel (out_valid_o / out_stall_i) returns exactly
// one result beat per input beat, in order. The close radius is written through
// cfg_we_i / cfg_wdata_i while the block is idle; the user must keep to this, as the
// block itself does not enforce it.
//
// Clear, the spare action code, a query on an open shape, an add on a closed shape and
// the first vertex go straight to the result; other adds first check the closing
// distance in S_RAD1 to S_RAD3; a query walks the store through its single read port,
// one vertex per cycle, into a 3-stage cross-product unit and then waits for it to drain.
// One item is worked at a time: in_stall_o is high from acceptance until the result is
// loaded into the output register and drops the cycle after. A stalled result holds in
// the output register and a finished item waits for it to drain before being loaded.
// Reset empties the shape, opens it, sets close_radius to 15 and drops any pending
// result. The vertex store itself is not cleared; only written entries are ever read.
module polygon_store_point_in_polygon #(
  parameter int unsigned MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int unsigned COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pip_pkg::RADIUS_W-1:0]        cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [pip_pkg::ACTION_W-1:0]        action_i,
  input  logic signed [COORD_WIDTH-1:0]       x_coord_i,
  input  logic signed [COORD_WIDTH-1:0]       y_coord_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [pip_pkg::STATUS_W-1:0]        status_o,
  output logic                                inside_res_o,
  output logic signed [COORD_WIDTH-1:0]       box_min_x_o,
  output logic signed [COORD_WIDTH-1:0]       box_min_y_o,
  output logic signed [COORD_WIDTH-1:0]       box_max_x_o,
  output logic signed [COORD_WIDTH-1:0]       box_max_y_o,
  output logic [pip_pkg::COUNT_OUT_W-1:0]     vertex_count_o
);

  import pip_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int unsigned AW    = $clog2(MAX_VERTICES);
  localparam int unsigned DW    = (COORD_WIDTH + 1 > RADIUS_W) ? COORD_WIDTH + 1 : RADIUS_W;
  localparam int unsigned SQ_W  = 2 * RADIUS_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD   = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_CLEAR = 2'd2
  } act_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED       = 3'd0,
    ST_CLOSED      = 3'd1,
    ST_IGN_CLOSED  = 3'd2,
    ST_IGN_FULL    = 3'd3,
    ST_QUERY       = 3'd4,
    ST_NOT_CLOSED  = 3'd5,
    ST_CLEARED     = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RAD1,
    S_RAD2,
    S_RAD3,
    S_WALK,
    S_DRAIN,
    S_DONE
  } state_e;

  state_e                         state_d, state_q;
  status_e                        res_d, res_q;
  logic [CNT_W-1:0]               count_d, count_q;
  logic                           closed_d, closed_q;
  logic [RADIUS_W-1:0]            radius_d, radius_q;
  logic signed [COORD_WIDTH-1:0]  first_x_d, first_x_q, first_y_d, first_y_q;
  logic signed [COORD_WIDTH-1:0]  px_d, px_q, py_d, py_q;
  logic [RADIUS_W-1:0]            dx_d, dx_q, dy_d, dy_q;
  logic                           far_d, far_q;
  logic [SQ_W-1:0]                dxsq_d, dxsq_q, dysq_d, dysq_q, rsq_d, rsq_q;
  logic [CNT_W-1:0]               rd_idx_d, rd_idx_q;
  logic                           rd_pend_d, rd_pend_q;
  logic signed [COORD_WIDTH-1:0]  prev_x_d, prev_x_q, prev_y_d, prev_y_q;
  logic signed [COORD_WIDTH-1:0]  bmin_x_d, bmin_x_q, bmin_y_d, bmin_y_q;
  logic signed [COORD_WIDTH-1:0]  bmax_x_d, bmax_x_q, bmax_y_d, bmax_y_q;
  logic                           out_valid_d, out_valid_q;
  logic [STATUS_W-1:0]            out_status_d, out_status_q;
  logic                           out_inside_d, out_inside_q;
  logic signed [COORD_WIDTH-1:0]  out_min_x_d, out_min_x_q, out_min_y_d, out_min_y_q;
  logic signed [COORD_WIDTH-1:0]  out_max_x_d, out_max_x_q, out_max_y_d, out_max_y_q;
  logic [COUNT_OUT_W-1:0]         out_cnt_d, out_cnt_q;

  // Vertex store port
  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr, mem_raddr;
  logic signed [COORD_WIDTH-1:0]  mem_wx, mem_wy, mem_rx, mem_ry;

  // Edge unit port
  edge_ctl_t                      edge_ctl;
  edge_sts_t                      edge_sts;
  logic signed [COORD_WIDTH-1:0]  edge_bx, edge_by;

  // Closing distance helpers
  logic [COORD_WIDTH:0]           dfx, dfy, mgx, mgy;
  logic [DW-1:0]                  mgx_ext, mgy_ext;
  logic [SQ_W:0]                  sq_sum;
  logic                           near;
  logic                           issue;
  logic [CNT_W+COUNT_OUT_W-1:0]   cnt_ext;

  // Distance to the first vertex, as magnitudes per axis
  always_comb begin
    dfx     = {px_q[COORD_WIDTH-1], px_q} - {first_x_q[COORD_WIDTH-1], first_x_q};
    dfy     = {py_q[COORD_WIDTH-1], py_q} - {first_y_q[COORD_WIDTH-1], first_y_q};
    mgx     = dfx[COORD_WIDTH] ? (~dfx + 1'b1) : dfx;
    mgy     = dfy[COORD_WIDTH] ? (~dfy + 1'b1) : dfy;
    mgx_ext = DW'(mgx);
    mgy_ext = DW'(mgy);
    sq_sum  = (SQ_W + 1)'(dxsq_q) + (SQ_W + 1)'(dysq_q);
    near    = !far_q && (sq_sum <= (SQ_W + 1)'(rsq_q));
    issue   = rd_idx_q < count_q;
    cnt_ext = (CNT_W + COUNT_OUT_W)'(count_q);
  end

  always_comb begin
    state_d      = state_q;
    res_d        = res_q;
    count_d      = count_q;
    closed_d     = closed_q;
    radius_d     = cfg_we_i ? cfg_wdata_i : radius_q;
    first_x_d    = first_x_q;
    first_y_d    = first_y_q;
    px_d         = px_q;
    py_d         = py_q;
    dx_d         = dx_q;
    dy_d         = dy_q;
    far_d        = far_q;
    dxsq_d       = dxsq_q;
    dysq_d       = dysq_q;
    rsq_d        = rsq_q;
    rd_idx_d     = rd_idx_q;
    rd_pend_d    = 1'b0;
    prev_x_d     = prev_x_q;
    prev_y_d     = prev_y_q;
    bmin_x_d     = bmin_x_q;
    bmin_y_d     = bmin_y_q;
    bmax_x_d     = bmax_x_q;
    bmax_y_d     = bmax_y_q;
    out_valid_d  = out_valid_q & out_stall_i;
    out_status_d = out_status_q;
    out_inside_d = out_inside_q;
    out_min_x_d  = out_min_x_q;
    out_min_y_d  = out_min_y_q;
    out_max_x_d  = out_max_x_q;
    out_max_y_d  = out_max_y_q;
    out_cnt_d    = out_cnt_q;
    mem_we       = 1'b0;
    mem_waddr    = count_q[AW-1:0];
    mem_wx       = px_q;
    mem_wy       = py_q;
    mem_raddr    = rd_idx_q[AW-1:0];
    edge_ctl     = '0;
    edge_bx      = first_x_q;
    edge_by      = first_y_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          px_d    = x_coord_i;
          py_d    = y_coord_i;
          state_d = S_DONE;
          case (act_e'(action_i))
            ACT_ADD: begin
              if (closed_q) begin
                res_d = ST_IGN_CLOSED;
              end else if (count_q == '0) begin
                // First vertex: store it and keep a copy for the closing test
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wx    = x_coord_i;
                mem_wy    = y_coord_i;
                first_x_d = x_coord_i;
                first_y_d = y_coord_i;
                count_d   = CNT_W'(1);
                res_d     = ST_ADDED;
              end else begin
                state_d = S_RAD1;
              end
            end
            ACT_QUERY: begin
              if (!closed_q || count_q == '0) begin
                res_d = ST_NOT_CLOSED;
              end else begin
                // Vertex 0 sits in registers; the walk reads from vertex 1 on
                rd_idx_d       = CNT_W'(1);
                prev_x_d       = first_x_q;
                prev_y_d       = first_y_q;
                bmin_x_d       = first_x_q;
                bmax_x_d       = first_x_q;
                bmin_y_d       = first_y_q;
                bmax_y_d       = first_y_q;
                edge_ctl.clear = 1'b1;
                res_d          = ST_QUERY;
                state_d        = S_WALK;
              end
            end
            ACT_CLEAR: begin
              count_d  = '0;
              closed_d = 1'b0;
              res_d    = ST_CLEARED;
            end
            default: begin
              // Unused action code: no state change, reported as cleared
              res_d = ST_CLEARED;
            end
          endcase
        end
      end

      S_RAD1: begin
        far_d   = (mgx_ext > DW'(radius_q)) || (mgy_ext > DW'(radius_q));
        dx_d    = mgx_ext[RADIUS_W-1:0];
        dy_d    = mgy_ext[RADIUS_W-1:0];
        state_d = S_RAD2;
      end

      S_RAD2: begin
        dxsq_d  = SQ_W'(dx_q) * SQ_W'(dx_q);
        dysq_d  = SQ_W'(dy_q) * SQ_W'(dy_q);
        rsq_d   = SQ_W'(radius_q) * SQ_W'(radius_q);
        state_d = S_RAD3;
      end

      S_RAD3: begin
        if (near) begin
          closed_d = 1'b1;
          res_d    = ST_CLOSED;
        end else if (count_q < CNT_W'(MAX_VERTICES)) begin
          mem_we  = 1'b1;
          count_d = count_q + CNT_W'(1);
          res_d   = ST_ADDED;
        end else begin
          res_d = ST_IGN_FULL;
        end
        state_d = S_DONE;
      end

      S_WALK: begin
        // Issue the next read while the previous one comes back
        if (issue) begin
          rd_idx_d = rd_idx_q + CNT_W'(1);
        end
        rd_pend_d = issue;
        if (rd_pend_q) begin
          edge_ctl.feed = 1'b1;
          edge_bx       = mem_rx;
          edge_by       = mem_ry;
          prev_x_d      = mem_rx;
          prev_y_d      = mem_ry;
          if (mem_rx < bmin_x_q) bmin_x_d = mem_rx;
          if (mem_rx > bmax_x_q) bmax_x_d = mem_rx;
          if (mem_ry < bmin_y_q) bmin_y_d = mem_ry;
          if (mem_ry > bmax_y_q) bmax_y_d = mem_ry;
        end else if (!issue) begin
          // Closing edge back to vertex 0
          edge_ctl.feed = 1'b1;
          state_d       = S_DRAIN;
        end
      end

      S_DRAIN: begin
        if (!edge_sts.busy) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_q;
          out_cnt_d    = cnt_ext[COUNT_OUT_W-1:0];
          if (res_q == ST_QUERY) begin
            out_inside_d = edge_sts.parity;
            out_min_x_d  = bmin_x_q;
            out_min_y_d  = bmin_y_q;
            out_max_x_d  = bmax_x_q;
            out_max_y_d  = bmax_y_q;
          end else begin
            out_inside_d = 1'b0;
            out_min_x_d  = '0;
            out_min_y_d  = '0;
            out_max_x_d  = '0;
            out_max_y_d  = '0;
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      res_q        <= ST_ADDED;
      count_q      <= '0;
      closed_q     <= 1'b0;
      radius_q     <= RADIUS_RESET;
      first_x_q    <= '0;
      first_y_q    <= '0;
      px_q         <= '0;
      py_q         <= '0;
      dx_q         <= '0;
      dy_q         <= '0;
      far_q        <= 1'b0;
      dxsq_q       <= '0;
      dysq_q       <= '0;
      rsq_q        <= '0;
      rd_idx_q     <= '0;
      rd_pend_q    <= 1'b0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      bmin_x_q     <= '0;
      bmin_y_q     <= '0;
      bmax_x_q     <= '0;
      bmax_y_q     <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_inside_q <= 1'b0;
      out_min_x_q  <= '0;
      out_min_y_q  <= '0;
      out_max_x_q  <= '0;
      out_max_y_q  <= '0;
      out_cnt_q    <= '0;
    end else begin
      state_q      <= state_d;
      res_q        <= res_d;
      count_q      <= count_d;
      closed_q     <= closed_d;
      radius_q     <= radius_d;
      first_x_q    <= first_x_d;
      first_y_q    <= first_y_d;
      px_q         <= px_d;
      py_q         <= py_d;
      dx_q         <= dx_d;
      dy_q         <= dy_d;
      far_q        <= far_d;
      dxsq_q       <= dxsq_d;
      dysq_q       <= dysq_d;
      rsq_q        <= rsq_d;
      rd_idx_q     <= rd_idx_d;
      rd_pend_q    <= rd_pend_d;
      prev_x_q     <= prev_x_d;
      prev_y_q     <= prev_y_d;
      bmin_x_q     <= bmin_x_d;
      bmin_y_q     <= bmin_y_d;
      bmax_x_q     <= bmax_x_d;
      bmax_y_q     <= bmax_y_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_inside_q <= out_inside_d;
      out_min_x_q  <= out_min_x_d;
      out_min_y_q  <= out_min_y_d;
      out_max_x_q  <= out_max_x_d;
      out_max_y_q  <= out_max_y_d;
      out_cnt_q    <= out_cnt_d;
    end
  end

  pip_vstore #(
    .DEPTH       (MAX_VERTICES),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_vstore (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wx_i    (mem_wx),
    .wy_i    (mem_wy),
    .raddr_i (mem_raddr),
    .rx_o    (mem_rx),
    .ry_o    (mem_ry)
  );

  pip_edge_unit #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (edge_ctl),
    .ax_i   (prev_x_q),
    .ay_i   (prev_y_q),
    .bx_i   (edge_bx),
    .by_i   (edge_by),
    .px_i   (px_q),
    .py_i   (py_q),
    .sts_o  (edge_sts)
  );

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign inside_res_o   = out_inside_q;
  assign box_min_x_o    = out_min_x_q;
  assign box_min_y_o    = out_min_y_q;
  assign box_max_x_o    = out_max_x_q;
  assign box_max_y_o    = out_max_y_q;
  assign vertex_count_o = out_cnt_q;

  a_closed_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    closed_q |-> (count_q != '0))
    else $error("shape closed with no stored vertex");

  a_feed_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_ctl.feed |-> (state_q == S_WALK))
    else $error("edge fed outside the vertex walk");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond store depth");

endmodule

/* rtl/core/pip_vstore.sv */
module pip_vstore #(
  parameter int unsigned DEPTH       = pip_pkg::MAX_VERTICES_DEF,
  parameter int unsigned COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  logic [COORD_WIDTH-1:0]     wx_i,
  input  logic [COORD_WIDTH-1:0]     wy_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [COORD_WIDTH-1:0]     rx_o,
  output logic [COORD_WIDTH-1:0]     ry_o
);

  logic [COORD_WIDTH-1:0] mem_x [DEPTH];
  logic [COORD_WIDTH-1:0] mem_y [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_x[waddr_i] <= wx_i;
      mem_y[waddr_i] <= wy_i;
    end
  end

  // Registered read, one address per cycle
  always_ff @(posedge clk_i) begin
    rx_o <= mem_x[raddr_i];
    ry_o <= mem_y[raddr_i];
  end

endmodule

/* rtl/core/pip_edge_unit.sv */
module pip_edge_unit #(
  parameter int unsigned COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pip_pkg::edge_ctl_t            ctl_i,
  input  logic signed [COORD_WIDTH-1:0] ax_i,
  input  logic signed [COORD_WIDTH-1:0] ay_i,
  input  logic signed [COORD_WIDTH-1:0] bx_i,
  input  logic signed [COORD_WIDTH-1:0] by_i,
  input  logic signed [COORD_WIDTH-1:0] px_i,
  input  logic signed [COORD_WIDTH-1:0] py_i,
  output pip_pkg::edge_sts_t            sts_o
);

  import pip_pkg::*;

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * DW;

  logic                 s1_vld_d, s1_vld_q, s2_vld_d, s2_vld_q;
  logic                 parity_d, parity_q;
  logic                 rel_d, s1_rel_q, s2_rel_q;
  logic                 up_d, s1_up_q, s2_up_q;
  logic signed [DW-1:0] dpy_d, dbx_d, dpx_d, dby_d;
  logic signed [DW-1:0] dpy_q, dbx_q, dpx_q, dby_q;
  logic signed [PW-1:0] p1_d, p2_d, p1_q, p2_q;
  logic                 hit;

  // Stage 1: differences and row range check
  always_comb begin
    up_d  = by_i > ay_i;
    rel_d = (ay_i != by_i) &&
            (up_d ? ((py_i >= ay_i) && (py_i <= by_i))
                  : ((py_i >= by_i) && (py_i <= ay_i)));
    dpy_d = DW'(py_i) - DW'(ay_i);
    dbx_d = DW'(bx_i) - DW'(ax_i);
    dpx_d = DW'(px_i) - DW'(ax_i);
    dby_d = DW'(by_i) - DW'(ay_i);
  end

  // Stage 2: the two cross products
  always_comb begin
    p1_d = PW'(dpy_q) * PW'(dbx_q);
    p2_d = PW'(dpx_q) * PW'(dby_q);
  end

  // Stage 3: compare and fold into the parity
  always_comb begin
    hit      = s2_vld_q && s2_rel_q && (s2_up_q ? (p1_q <= p2_q) : (p2_q <= p1_q));
    parity_d = ctl_i.clear ? 1'b0 : (parity_q ^ hit);
    s1_vld_d = ctl_i.feed;
    s2_vld_d = s1_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      parity_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
      s2_vld_q <= s2_vld_d;
      parity_q <= parity_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_rel_q <= rel_d;
    s1_up_q  <= up_d;
    dpy_q    <= dpy_d;
    dbx_q    <= dbx_d;
    dpx_q    <= dpx_d;
    dby_q    <= dby_d;
    s2_rel_q <= s1_rel_q;
    s2_up_q  <= s1_up_q;
    p1_q     <= p1_d;
    p2_q     <= p2_d;
  end

  assign sts_o.busy   = s1_vld_q | s2_vld_q;
  assign sts_o.parity = parity_q;

  a_no_clear_with_feed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_i.clear && ctl_i.feed))
    else $error("edge unit cleared while fed");

  a_stage_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |=> s2_vld_q)
    else $error("edge lost between stages");

  a_parity_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s2_vld_q && !ctl_i.clear) |=> $stable(parity_q))
    else $error("parity changed with no edge in the last stage");

endmodule
